// ----- rtl/hec_pkg.sv -----
// ----------------------------------------------------------------------------
// hec_pkg
// Shared types, widths and helpers for the homogeneous edge clipper.
// ----------------------------------------------------------------------------
package hec_pkg;

  localparam int NumPlanes = 6;   // left, right, bottom, top, near, far
  localparam int NumComp   = 4;   // x, y, z, w
  localparam int CoordW    = 32;
  localparam int BndW      = 34;  // exact boundary value w +/- coord
  localparam int DiffW     = 33;  // b - a per component
  localparam int QuotW     = 18;  // floor(n * 2^17 / d)
  localparam int ParW      = 17;  // unsigned Q1.16 parameter
  localparam int ProdW     = DiffW + ParW + 1;
  localparam int DivSteps  = QuotW;

  localparam logic [ParW-1:0] ParOne = ParW'(65536);

  typedef enum logic [1:0] {
    PS_ALL = 2'd0,
    PS_X   = 2'd1,
    PS_Y   = 2'd2,
    PS_Z   = 2'd3
  } plane_set_e;

  typedef enum logic [2:0] {
    ST_ACCEPT  = 3'd0,
    ST_REJECT  = 3'd1,
    ST_MOVE_A  = 3'd2,
    ST_MOVE_B  = 3'd3,
    ST_MOVE_AB = 3'd4
  } status_e;

  typedef logic [NumComp-1:0][CoordW-1:0] vec_t;
  typedef logic [NumComp-1:0][DiffW-1:0]  dvec_t;
  typedef logic [NumPlanes-1:0]           ocode_t;

  // Edge data carried alongside the division
  typedef struct packed {
    vec_t   a;
    vec_t   b;
    dvec_t  diff;
    ocode_t oa;
    ocode_t ob;
  } seg_t;

  // One divider pipeline word: six lanes of remainder, divisor, quotient
  typedef struct packed {
    seg_t                                seg;
    logic [NumPlanes-1:0][BndW-1:0]      r;
    logic [NumPlanes-1:0][BndW-1:0]      d;
    logic [NumPlanes-1:0][QuotW-1:0]     q;
  } div_t;

  function automatic logic [BndW-1:0] sx_bnd(input logic [CoordW-1:0] v);
    return {{(BndW-CoordW){v[CoordW-1]}}, v};
  endfunction

  function automatic logic [DiffW-1:0] sx_diff(input logic [CoordW-1:0] v);
    return {{(DiffW-CoordW){v[CoordW-1]}}, v};
  endfunction

  function automatic ocode_t plane_mask(input plane_set_e ps);
    ocode_t m;
    case (ps)
      PS_X:    m = 6'b000011;
      PS_Y:    m = 6'b001100;
      PS_Z:    m = 6'b110000;
      default: m = 6'b111111;
    endcase
    return m;
  endfunction

endpackage

// ----- rtl/hec_front.sv -----
// ----------------------------------------------------------------------------
// hec_front
// Boundary values, outcodes and divider operands, two register stages.
// ----------------------------------------------------------------------------
module hec_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            plane_set_i,
  input  hec_pkg::vec_t         a_i,
  input  hec_pkg::vec_t         b_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hec_pkg::div_t         out_data_o
);
  import hec_pkg::*;

  logic                           v1_q, v2_q, en1, en2;
  logic [1:0]                     ps_q;
  vec_t                           a1_q, b1_q;
  logic [NumPlanes-1:0][BndW-1:0] ab_d, bb_d, ab_q, bb_q;
  div_t                           s2_d, s2_q;

  assign en2         = !v2_q || out_ready_i;
  assign en1         = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v2_q;
  assign out_data_o  = s2_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab_d[2*k]   = sx_bnd(a_i[3]) + sx_bnd(a_i[k]);
      ab_d[2*k+1] = sx_bnd(a_i[3]) - sx_bnd(a_i[k]);
      bb_d[2*k]   = sx_bnd(b_i[3]) + sx_bnd(b_i[k]);
      bb_d[2*k+1] = sx_bnd(b_i[3]) - sx_bnd(b_i[k]);
    end
  end

  always_comb begin
    ocode_t m;
    m = plane_mask(plane_set_e'(ps_q));
    s2_d.seg.a = a1_q;
    s2_d.seg.b = b1_q;
    for (int k = 0; k < NumComp; k++) begin
      s2_d.seg.diff[k] = sx_diff(b1_q[k]) - sx_diff(a1_q[k]);
    end
    for (int i = 0; i < NumPlanes; i++) begin
      s2_d.seg.oa[i] = ab_q[i][BndW-1] & m[i];
      s2_d.seg.ob[i] = bb_q[i][BndW-1] & m[i];
      // numerator |a|, divisor |a| + |b| when the signs differ
      s2_d.r[i] = ab_q[i][BndW-1] ? (BndW'(0) - ab_q[i]) : ab_q[i];
      s2_d.d[i] = ab_q[i][BndW-1] ? (bb_q[i] - ab_q[i]) : (ab_q[i] - bb_q[i]);
      s2_d.q[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ps_q <= plane_set_i;
      a1_q <= a_i;
      b1_q <= b_i;
      ab_q <= ab_d;
      bb_q <= bb_d;
    end
    if (en2) s2_q <= s2_d;
  end

endmodule

// ----- rtl/hec_divider.sv -----
// ----------------------------------------------------------------------------
// hec_divider
// Six-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module hec_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hec_pkg::div_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hec_pkg::div_t out_data_o
);
  import hec_pkg::*;

  logic [DivSteps-1:0] v_q, v_in, en;
  div_t                src  [DivSteps];
  div_t                st_d [DivSteps];
  div_t                st_q [DivSteps];

  always_comb begin
    en[DivSteps-1] = !v_q[DivSteps-1] || out_ready_i;
    for (int j = DivSteps - 2; j >= 0; j--) begin
      en[j] = !v_q[j] || en[j+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[DivSteps-1];
  assign out_data_o  = st_q[DivSteps-1];

  // stage inputs: the new transaction for the first stage, else the stage before
  assign v_in = {v_q[DivSteps-2:0], in_valid_i};

  always_comb begin
    src[0] = in_data_i;
    for (int j = 1; j < DivSteps; j++) begin
      src[j] = st_q[j-1];
    end
  end

  always_comb begin
    logic [BndW:0]   s;
    logic            ge;
    for (int j = 0; j < DivSteps; j++) begin
      st_d[j] = src[j];
      for (int i = 0; i < NumPlanes; i++) begin
        // first step tests n >= d, later steps shift the remainder
        s  = (j == 0) ? {1'b0, src[j].r[i]} : {src[j].r[i], 1'b0};
        ge = (s >= {1'b0, src[j].d[i]});
        st_d[j].r[i] = ge ? BndW'(s - {1'b0, src[j].d[i]}) : s[BndW-1:0];
        st_d[j].q[i] = {src[j].q[i][QuotW-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int j = 0; j < DivSteps; j++) begin
        if (en[j]) v_q[j] <= v_in[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DivSteps; j++) begin
      if (en[j]) st_q[j] <= st_d[j];
    end
  end

endmodule

// ----- rtl/hec_back.sv -----
// ----------------------------------------------------------------------------
// hec_back
// Parameter selection, interpolation products and endpoint assembly.
// ----------------------------------------------------------------------------
module hec_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  hec_pkg::div_t            in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [2:0]               status_o,
  output hec_pkg::vec_t            new_a_o,
  output hec_pkg::vec_t            new_b_o,
  output logic [16:0]              t_enter_o,
  output logic [16:0]              t_leave_o
);
  import hec_pkg::*;

  logic v1_q, v2_q, v3_q, en1, en2, en3;

  // stage 1: parameters and status
  logic [ParW-1:0] ta_d, tb_d, ta1_q, tb1_q, ta2_q, tb2_q;
  status_e         st_d, st1_q, st2_q, st3_q;
  vec_t            a1_q, b1_q, a2_q, b2_q;
  dvec_t           diff1_q;
  // stage 2: products
  logic [NumComp-1:0][ProdW-1:0] pa_d, pb_d, pa_q, pb_q;
  // stage 3: outputs
  vec_t            na_d, nb_d, na_q, nb_q;
  logic [ParW-1:0] te_q, tl_q;

  assign en3         = !v3_q || out_ready_i;
  assign en2         = !v2_q || en3;
  assign en1         = !v1_q || en2;
  assign in_ready_o  = en1;
  assign out_valid_o = v3_q;
  assign status_o    = st3_q;
  assign new_a_o     = na_q;
  assign new_b_o     = nb_q;
  assign t_enter_o   = te_q;
  assign t_leave_o   = tl_q;

  always_comb begin
    logic [QuotW-1:0] qr;
    logic [ParW-1:0]  t;
    ocode_t           oa, ob;
    oa   = in_data_i.seg.oa;
    ob   = in_data_i.seg.ob;
    ta_d = '0;
    tb_d = ParOne;
    for (int i = 0; i < NumPlanes; i++) begin
      // round half up: (floor(n * 2^17 / d) + 1) / 2
      qr = in_data_i.q[i] + QuotW'(1);
      t  = qr[QuotW-1:1];
      if (oa[i]) begin
        if (t > ta_d) ta_d = t;
      end else if (ob[i]) begin
        if (t < tb_d) tb_d = t;
      end
    end
    if ((oa | ob) == '0)          st_d = ST_ACCEPT;
    else if ((oa & ob) != '0)     st_d = ST_REJECT;
    else if (ta_d > tb_d)         st_d = ST_REJECT;
    else if (oa != '0 && ob != '0) st_d = ST_MOVE_AB;
    else if (oa != '0)            st_d = ST_MOVE_A;
    else                          st_d = ST_MOVE_B;
  end

  always_comb begin
    for (int k = 0; k < NumComp; k++) begin
      pa_d[k] = ProdW'($signed(diff1_q[k]) * $signed({1'b0, ta1_q}));
      pb_d[k] = ProdW'($signed(diff1_q[k]) * $signed({1'b0, tb1_q}));
    end
  end

  always_comb begin
    logic [ProdW-1:0] ra, rb;
    logic             mva, mvb;
    mva = (st2_q == ST_MOVE_A) || (st2_q == ST_MOVE_AB);
    mvb = (st2_q == ST_MOVE_B) || (st2_q == ST_MOVE_AB);
    for (int k = 0; k < NumComp; k++) begin
      ra = pa_q[k] + ProdW'(32768);
      rb = pb_q[k] + ProdW'(32768);
      na_d[k] = mva ? (a2_q[k] + ra[CoordW+15:16]) : a2_q[k];
      nb_d[k] = mvb ? (a2_q[k] + rb[CoordW+15:16]) : b2_q[k];
      if (st2_q == ST_REJECT) begin
        na_d[k] = '0;
        nb_d[k] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      ta1_q   <= ta_d;
      tb1_q   <= tb_d;
      st1_q   <= st_d;
      a1_q    <= in_data_i.seg.a;
      b1_q    <= in_data_i.seg.b;
      diff1_q <= in_data_i.seg.diff;
    end
    if (en2) begin
      pa_q  <= pa_d;
      pb_q  <= pb_d;
      ta2_q <= ta1_q;
      tb2_q <= tb1_q;
      st2_q <= st1_q;
      a2_q  <= a1_q;
      b2_q  <= b1_q;
    end
    if (en3) begin
      na_q  <= na_d;
      nb_q  <= nb_d;
      st3_q <= st2_q;
      te_q  <= (st2_q == ST_REJECT) ? '0 : ta2_q;
      tl_q  <= (st2_q == ST_REJECT) ? '0 : tb2_q;
    end
  end

endmodule

// ----- rtl/homogeneous_edge_clipper.sv -----
// ----------------------------------------------------------------------------
// homogeneous_edge_clipper
// Liang-Barsky clipping of one edge in homogeneous clip space, Q16.16.
// ----------------------------------------------------------------------------
//  channel | handshake               | payload
//  --------+-------------------------+----------------------------------------
//  in      | in_valid_i / in_ready_o | plane_set_i, ax_i .. aw_i, bx_i .. bw_i
//  out     | out_valid_o/out_ready_i | status_o, new_a*_o, new_b*_o, t_*_o
//
//  One transaction enters per cycle unless stalled; it passes two front stages,
//  eighteen divider stages (one quotient bit each) and three back stages.
//  Every stage has its own valid bit and loads when it or the stage after it
//  is free, so bubbles close up and a stall at the output loses nothing.
//  Reset clears only the valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module homogeneous_edge_clipper (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  plane_set_i,
  input  logic [31:0] ax_i,
  input  logic [31:0] ay_i,
  input  logic [31:0] az_i,
  input  logic [31:0] aw_i,
  input  logic [31:0] bx_i,
  input  logic [31:0] by_coord_i,
  input  logic [31:0] bz_i,
  input  logic [31:0] bw_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] new_ax_o,
  output logic [31:0] new_ay_o,
  output logic [31:0] new_az_o,
  output logic [31:0] new_aw_o,
  output logic [31:0] new_bx_o,
  output logic [31:0] new_by_o,
  output logic [31:0] new_bz_o,
  output logic [31:0] new_bw_o,
  output logic [16:0] t_enter_o,
  output logic [16:0] t_leave_o
);
  import hec_pkg::*;

  vec_t  a, b, new_a, new_b;
  div_t  fd_data, dv_data;
  logic  fd_valid, fd_ready, dv_valid, dv_ready;

  // pack endpoints as x, y, z, w
  assign a = {aw_i, az_i, ay_i, ax_i};
  assign b = {bw_i, bz_i, by_coord_i, bx_i};

  // boundary values, outcodes, divider operands
  hec_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .plane_set_i (plane_set_i),
    .a_i         (a),
    .b_i         (b),
    .out_valid_o (fd_valid),
    .out_ready_i (fd_ready),
    .out_data_o  (fd_data)
  );

  // per-plane crossing parameter, all six lanes in step
  hec_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fd_valid),
    .in_ready_o  (fd_ready),
    .in_data_i   (fd_data),
    .out_valid_o (dv_valid),
    .out_ready_i (dv_ready),
    .out_data_o  (dv_data)
  );

  // entry/exit selection, interpolation, output register
  hec_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dv_valid),
    .in_ready_o  (dv_ready),
    .in_data_i   (dv_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_o    (status_o),
    .new_a_o     (new_a),
    .new_b_o     (new_b),
    .t_enter_o   (t_enter_o),
    .t_leave_o   (t_leave_o)
  );

  assign new_ax_o = new_a[0];
  assign new_ay_o = new_a[1];
  assign new_az_o = new_a[2];
  assign new_aw_o = new_a[3];
  assign new_bx_o = new_b[0];
  assign new_by_o = new_b[1];
  assign new_bz_o = new_b[2];
  assign new_bw_o = new_b[3];

endmodule
